>>> hdl/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg: shared types and constants for the video scroll address unit
// Operation, register and request codes, timing constants, address masks and
// the structs passed between the state core, the sprite memory and the top.
// ----------------------------------------------------------------------------
package vsa_pkg;

    // frame timing
    localparam int DOTS_PER_LINE = 341;
    localparam int LAST_LINE     = 260;
    localparam int SPRITE_BYTES  = 256;
    localparam int SPRITE_AW     = $clog2(SPRITE_BYTES);

    // special lines and dots
    localparam logic signed [9:0] LINE_PRE    = -10'sd1;
    localparam logic signed [9:0] LINE_VBLANK = 10'sd241;
    localparam logic signed [9:0] LINE_LAST   = 10'(LAST_LINE);
    localparam logic [8:0] DOT_LAST        = 9'(DOTS_PER_LINE - 1);
    localparam logic [8:0] DOT_FLAG        = 9'd1;
    localparam logic [8:0] DOT_FINE_Y      = 9'd256;
    localparam logic [8:0] DOT_HORIZ_COPY  = 9'd257;
    localparam logic [8:0] DOT_VERT_FIRST  = 9'd280;
    localparam logic [8:0] DOT_VERT_LAST   = 9'd304;

    // address field masks
    localparam logic [14:0] FINE_Y_MASK     = 15'h7000;
    localparam logic [14:0] COARSE_Y_MASK   = 15'h03E0;
    localparam logic [14:0] HORIZ_COPY_MASK = 15'h041F;
    localparam logic [14:0] VERT_COPY_MASK  = 15'h7BE0;
    localparam logic [14:0] NT_X_BIT        = 15'h0400;
    localparam logic [14:0] NT_Y_BIT        = 15'h0800;
    localparam logic [14:0] VRAM_ADDR_MASK  = 15'h3FFF;
    localparam logic [7:0]  RENDER_MASK     = 8'h1E;

    // item kind carried in tuser
    typedef enum logic [1:0] {
        OP_DOT   = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // CPU register offsets
    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } reg_t;

    // VRAM request codes
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // result of one item, sprite byte still pending
    typedef struct packed {
        logic              oam_read;
        logic [7:0]        read_data;
        logic [1:0]        vram_request;
        logic [13:0]       vram_addr;
        logic [7:0]        vram_wdata;
        logic              vblank_flag;
        logic [8:0]        dot_now;
        logic signed [9:0] line_now;
    } vsa_result_t;

    // sprite memory access
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [SPRITE_AW-1:0] addr;
        logic [7:0]           wdata;
    } vsa_ram_req_t;

endpackage

>>> hdl/video_scroll_address_unit.sv
// ----------------------------------------------------------------------------
// video_scroll_address_unit: register and scroll address side of a tile
// video processor
// Dot ticks, CPU register writes and reads in; one result per item out,
// carrying the read byte, any VRAM request and the timing counters.
//
//   channel  | direction | tdata                                   | tuser
//   s_axis   | in        | reg_index, write_data                   | operation
//   m_axis   | out       | read_data, vram_addr, vram_wdata,       | vram_request
//            |           | vblank_flag, dot_now, line_now          |
//
// One item per cycle sustained while m_axis is not stalled; each result is
// registered in stage 1 (with the sprite memory read) and then in the output stage.
// Reset clears all control state; sprite memory content is undefined until
// written. Stalls on m_axis back up through the two stages, so s_axis keeps
// accepting while either stage has room.
// ----------------------------------------------------------------------------
module video_scroll_address_unit
    import vsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] reg_index, [10:3] write_data
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [7:0] read_data, [21:8] vram_addr,
                                        // [29:22] vram_wdata, [30] vblank_flag,
                                        // [39:31] dot_now, [49:40] line_now
    output logic [1:0]  m_axis_tuser    // [1:0] vram_request
);

    logic         s_accept;
    logic         out_ready;
    logic         s1_ready;
    vsa_result_t  core_res;
    vsa_ram_req_t ram_req;
    logic [7:0]   ram_rdata;

    logic         s1_valid_reg;
    vsa_result_t  s1_res_reg;
    logic         out_valid_reg;
    logic [55:0]  out_data_reg;
    logic [1:0]   out_user_reg;
    logic [7:0]   s1_read_data;

    // handshake chain
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s1_ready      = !s1_valid_reg || out_ready;
    assign s_axis_tready = s1_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    vsa_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (s_accept),
        .operation  (s_axis_tuser),
        .reg_index  (s_axis_tdata[2:0]),
        .write_data (s_axis_tdata[10:3]),
        .res        (core_res),
        .ram        (ram_req)
    );

    vsa_sprite_ram #(
        .DEPTH (SPRITE_BYTES),
        .WIDTH (8)
    ) u_sprite_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // stage 1 valid: waits for the sprite memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_res_reg <= core_res;
        end
    end

    assign s1_read_data = s1_res_reg.oam_read ? ram_rdata : s1_res_reg.read_data;

    // output stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            out_data_reg <= {6'd0,
                             s1_res_reg.line_now,
                             s1_res_reg.dot_now,
                             s1_res_reg.vblank_flag,
                             s1_res_reg.vram_wdata,
                             s1_res_reg.vram_addr,
                             s1_read_data};
            out_user_reg <= s1_res_reg.vram_request;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // a dot tick never produces a VRAM request
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_axis_tuser == OP_DOT |=> s1_res_reg.vram_request == REQ_NONE)
        else $error("dot tick produced a vram request");

    // without a request the address and write byte are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == REQ_NONE |->
            m_axis_tdata[29:8] == 22'd0)
        else $error("vram address or data set without a request");

    // a full pipeline must not take a new transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while both stages are full");

    // dot counter stays inside the line
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:31] <= DOT_LAST)
        else $error("dot counter out of range");

endmodule

>>> hdl/vsa_sprite_ram.sv
// ----------------------------------------------------------------------------
// vsa_sprite_ram: single-port synchronous RAM
// One write or one read per cycle; read data is registered and holds until
// the next read.
// ----------------------------------------------------------------------------
module vsa_sprite_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/vsa_core.sv
// ----------------------------------------------------------------------------
// vsa_core: register state and scroll address update
// Holds the dot and line counters, status, control, mask, sprite address,
// current and temporary VRAM addresses and the write toggle. Updates them
// for each transfer and forms the result and the sprite memory access.
// ----------------------------------------------------------------------------
module vsa_core
    import vsa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [1:0]   operation,
    input  logic [2:0]   reg_index,
    input  logic [7:0]   write_data,
    output vsa_result_t  res,
    output vsa_ram_req_t ram
);

    logic [8:0]        dot_reg,      dot_next;
    logic signed [9:0] line_reg,     line_next;
    logic              vblank_reg,   vblank_next;
    logic [7:0]        ctrl_reg,     ctrl_next;
    logic [7:0]        mask_reg,     mask_next;
    logic [7:0]        oam_addr_reg, oam_addr_next;
    logic [14:0]       v_reg,        v_next;
    logic [14:0]       t_reg,        t_next;
    logic              w_reg,        w_next;

    logic              render_on;
    logic [14:0]       t_tmp;

    // coarse x step with horizontal nametable wrap
    function automatic logic [14:0] step_coarse_x(input logic [14:0] a);
        logic [14:0] r;
        if (a[4:0] == 5'd31)
        begin
            r = (a & ~15'h001F) ^ NT_X_BIT;
        end
        else
        begin
            r = a + 15'd1;
        end
        return r;
    endfunction

    // fine y step with coarse y and vertical nametable wrap
    function automatic logic [14:0] step_fine_y(input logic [14:0] a);
        logic [14:0] r;
        logic [4:0]  y;
        if ((a & FINE_Y_MASK) != FINE_Y_MASK)
        begin
            r = a + 15'h1000;
        end
        else
        begin
            r = a & ~FINE_Y_MASK;
            y = a[9:5];
            if (y == 5'd29)
            begin
                y = 5'd0;
                r = r ^ NT_Y_BIT;
            end
            else if (y == 5'd31)
            begin
                y = 5'd0;
            end
            else
            begin
                y = y + 5'd1;
            end
            r[9:5] = y;
        end
        return r;
    endfunction

    assign render_on = (mask_reg & RENDER_MASK) != 8'd0;

    // next state and result
    always_comb
    begin
        dot_next      = dot_reg;
        line_next     = line_reg;
        vblank_next   = vblank_reg;
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        oam_addr_next = oam_addr_reg;
        v_next        = v_reg;
        t_next        = t_reg;
        w_next        = w_reg;
        t_tmp         = t_reg;

        res           = '0;
        ram           = '0;
        ram.addr      = oam_addr_reg;
        ram.wdata     = write_data;

        case (operation)
            OP_DOT:
            begin
                // status flag at dot 1
                if (dot_reg == DOT_FLAG)
                begin
                    if (line_reg == LINE_VBLANK)
                    begin
                        vblank_next = 1'b1;
                    end
                    else if (line_reg == LINE_PRE)
                    begin
                        vblank_next = 1'b0;
                    end
                end
                // scroll address steps
                if (render_on)
                begin
                    if (dot_reg == DOT_FINE_Y)
                    begin
                        v_next = step_fine_y(v_reg);
                    end
                    else if (dot_reg == DOT_HORIZ_COPY)
                    begin
                        v_next = (v_reg & ~HORIZ_COPY_MASK) | (t_reg & HORIZ_COPY_MASK);
                    end
                    else if (dot_reg >= DOT_VERT_FIRST && dot_reg <= DOT_VERT_LAST
                             && line_reg == LINE_PRE)
                    begin
                        v_next = (v_reg & ~VERT_COPY_MASK) | (t_reg & VERT_COPY_MASK);
                    end
                    else if (dot_reg != 9'd0 && dot_reg[2:0] == 3'd0)
                    begin
                        v_next = step_coarse_x(v_reg);
                    end
                end
                // dot and line counters
                if (dot_reg == DOT_LAST)
                begin
                    dot_next = 9'd0;
                    if (line_reg == LINE_LAST)
                    begin
                        line_next = LINE_PRE;
                    end
                    else
                    begin
                        line_next = line_reg + 10'sd1;
                    end
                end
                else
                begin
                    dot_next = dot_reg + 9'd1;
                end
            end
            OP_WRITE:
            begin
                case (reg_index)
                    REG_CTRL:
                    begin
                        ctrl_next       = write_data;
                        t_next[11:10]   = write_data[1:0];
                    end
                    REG_MASK:
                    begin
                        mask_next = write_data;
                    end
                    REG_OAM_ADDR:
                    begin
                        oam_addr_next = write_data;
                    end
                    REG_OAM_DATA:
                    begin
                        ram.we        = accept;
                        oam_addr_next = oam_addr_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (w_reg)
                        begin
                            t_next[14:12] = write_data[2:0];
                            t_next[9:5]   = write_data[7:3];
                        end
                        else
                        begin
                            t_next[4:0] = write_data[7:3];
                        end
                        w_next = ~w_reg;
                    end
                    REG_ADDR:
                    begin
                        if (w_reg)
                        begin
                            t_tmp  = {t_reg[14:8], write_data};
                            t_next = t_tmp;
                            v_next = t_tmp;
                        end
                        else
                        begin
                            t_next = {1'b0, write_data[5:0], t_reg[7:0]};
                        end
                        w_next = ~w_reg;
                    end
                    REG_DATA:
                    begin
                        res.vram_request = REQ_WRITE;
                        res.vram_addr    = v_reg[13:0];
                        res.vram_wdata   = write_data;
                        v_next = v_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_READ:
            begin
                case (reg_index)
                    REG_STATUS:
                    begin
                        res.read_data = {vblank_reg, 7'd0};
                        vblank_next   = 1'b0;
                        w_next        = 1'b0;
                    end
                    REG_OAM_DATA:
                    begin
                        ram.re       = accept;
                        res.oam_read = 1'b1;
                    end
                    REG_DATA:
                    begin
                        res.vram_request = REQ_READ;
                        res.vram_addr    = v_reg[13:0];
                        v_next = v_reg + (ctrl_reg[2] ? 15'd32 : 15'd1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        res.vblank_flag = vblank_next;
        res.dot_now     = dot_next;
        res.line_now    = line_next;
    end

    // state registers, updated on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg      <= 9'd0;
            line_reg     <= LINE_PRE;
            vblank_reg   <= 1'b0;
            ctrl_reg     <= 8'd0;
            mask_reg     <= 8'd0;
            oam_addr_reg <= 8'd0;
            v_reg        <= 15'd0;
            t_reg        <= 15'd0;
            w_reg        <= 1'b0;
        end
        else if (accept)
        begin
            dot_reg      <= dot_next;
            line_reg     <= line_next;
            vblank_reg   <= vblank_next;
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            oam_addr_reg <= oam_addr_next;
            v_reg        <= v_next;
            t_reg        <= t_next;
            w_reg        <= w_next;
        end
    end

endmodule

>>> dv/vsa_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// vsa_scoreboard_pkg: scroll register predictor and result checker
// Tracks the dot and line counters, status bits, control and mask bytes,
// loopy current and temporary addresses, the write toggle and sprite memory.
// Each accepted item queues the result it must produce, and each result
// transfer is checked against the oldest queued one.
// ----------------------------------------------------------------------------
package vsa_scoreboard_pkg;

    import vsa_pkg::*;

    // one result as seen on the output stream
    typedef struct packed {
        logic [7:0]        read_data;
        logic [1:0]        vram_request;
        logic [13:0]       vram_addr;
        logic [7:0]        vram_wdata;
        logic              vblank_flag;
        logic [8:0]        dot_now;
        logic signed [9:0] line_now;
    } scroll_result_t;

    class scroll_scoreboard;

        // mirrored block state
        logic [8:0]        dot;
        logic signed [9:0] line;
        logic [2:0]        status;
        logic [7:0]        ctrl;
        logic [7:0]        mask;
        logic [7:0]        oam_addr;
        logic [7:0]        oam_mem [SPRITE_BYTES];
        bit                oam_written [SPRITE_BYTES];
        logic [14:0]       cur_v;
        logic [14:0]       tmp_v;
        logic [2:0]        fine_x;
        logic              toggle;

        scroll_result_t    pending_outputs [$];
        int                failures;

        function new();
            dot      = '0;
            line     = LINE_PRE;
            status   = '0;
            ctrl     = '0;
            mask     = '0;
            oam_addr = '0;
            cur_v    = '0;
            tmp_v    = '0;
            fine_x   = '0;
            toggle   = 1'b0;
            failures = 0;
            foreach (oam_written[i]) oam_written[i] = 1'b0;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        // coarse x step with horizontal nametable wrap
        function void coarse_x_step();
            if (cur_v[4:0] == 5'd31) begin
                cur_v[4:0] = 5'd0;
                cur_v      = cur_v ^ NT_X_BIT;
            end else begin
                cur_v = cur_v + 15'd1;
            end
        endfunction

        // fine y step, coarse y wraps at 29 with nametable flip, at 31 without
        function void fine_y_step();
            logic [4:0] y;
            if ((cur_v & FINE_Y_MASK) != FINE_Y_MASK) begin
                cur_v = cur_v + 15'h1000;
            end else begin
                cur_v = cur_v & ~FINE_Y_MASK;
                y = cur_v[9:5];
                if (y == 5'd29) begin
                    y     = 5'd0;
                    cur_v = cur_v ^ NT_Y_BIT;
                end else if (y == 5'd31) begin
                    y = 5'd0;
                end else begin
                    y = y + 5'd1;
                end
                cur_v[9:5] = y;
            end
        endfunction

        function void dot_step();
            if (dot == DOT_FLAG) begin
                if (line == LINE_VBLANK)
                    status = status | 3'b100;
                else if (line == LINE_PRE)
                    status = 3'b000;
            end
            // address steps only while rendering
            if ((mask & RENDER_MASK) != 8'h00) begin
                if (dot == DOT_FINE_Y)
                    fine_y_step();
                else if (dot == DOT_HORIZ_COPY)
                    cur_v = (cur_v & ~HORIZ_COPY_MASK) | (tmp_v & HORIZ_COPY_MASK);
                else if (dot >= DOT_VERT_FIRST && dot <= DOT_VERT_LAST && line == LINE_PRE)
                    cur_v = (cur_v & ~VERT_COPY_MASK) | (tmp_v & VERT_COPY_MASK);
                else if (dot != 9'd0 && dot[2:0] == 3'd0)
                    coarse_x_step();
            end
            // counters
            if (dot == DOT_LAST) begin
                dot  = 9'd0;
                line = line + 10'sd1;
                if (line > LINE_LAST)
                    line = LINE_PRE;
            end else begin
                dot = dot + 9'd1;
            end
        endfunction

        function void data_port_step();
            cur_v = cur_v + (ctrl[2] ? 15'd32 : 15'd1);
        endfunction

        // advance the mirror by one accepted item and queue its result
        function void predict_item(op_t op, reg_t ri, logic [7:0] d);
            scroll_result_t r;
            r = '0;
            case (op)
                OP_DOT: dot_step();
                OP_WRITE: begin
                    case (ri)
                        REG_CTRL: begin
                            ctrl          = d;
                            tmp_v[11:10]  = d[1:0];
                        end
                        REG_MASK:     mask = d;
                        REG_OAM_ADDR: oam_addr = d;
                        REG_OAM_DATA: begin
                            oam_mem[oam_addr]     = d;
                            oam_written[oam_addr] = 1'b1;
                            oam_addr              = oam_addr + 8'd1;
                        end
                        REG_SCROLL: begin
                            if (toggle) begin
                                tmp_v[14:12] = d[2:0];
                                tmp_v[9:5]   = d[7:3];
                            end else begin
                                tmp_v[4:0] = d[7:3];
                                fine_x     = d[2:0];
                            end
                            toggle = ~toggle;
                        end
                        REG_ADDR: begin
                            if (toggle) begin
                                tmp_v[7:0] = d;
                                cur_v      = tmp_v;
                            end else begin
                                tmp_v[14]   = 1'b0;
                                tmp_v[13:8] = d[5:0];
                            end
                            toggle = ~toggle;
                        end
                        REG_DATA: begin
                            r.vram_request = REQ_WRITE;
                            r.vram_addr    = cur_v[13:0];
                            r.vram_wdata   = d;
                            data_port_step();
                        end
                        default: ;
                    endcase
                end
                OP_READ: begin
                    case (ri)
                        REG_STATUS: begin
                            r.read_data = {status, 5'b00000};
                            status[2]   = 1'b0;
                            toggle      = 1'b0;
                        end
                        REG_OAM_DATA: r.read_data = oam_mem[oam_addr];
                        REG_DATA: begin
                            r.vram_request = REQ_READ;
                            r.vram_addr    = cur_v[13:0];
                            data_port_step();
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            r.vblank_flag = status[2];
            r.dot_now     = dot;
            r.line_now    = line;
            pending_outputs.push_back(r);
        endfunction

        // compare one result transfer with the oldest prediction
        function void check_result(logic [55:0] tdata, logic [1:0] tuser);
            scroll_result_t got;
            scroll_result_t exp;
            got.read_data    = tdata[7:0];
            got.vram_addr    = tdata[21:8];
            got.vram_wdata   = tdata[29:22];
            got.vblank_flag  = tdata[30];
            got.dot_now      = tdata[39:31];
            got.line_now     = tdata[49:40];
            got.vram_request = tuser;
            if (pending_outputs.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: tdata=%014h tuser=%0d", tdata, tuser);
                return;
            end
            exp = pending_outputs.pop_front();
            if (got !== exp) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch exp: rd=%02h req=%0d addr=%04h wd=%02h vb=%0d dot=%0d line=%0d",
                             exp.read_data, exp.vram_request, exp.vram_addr, exp.vram_wdata,
                             exp.vblank_flag, exp.dot_now, exp.line_now);
                    $display("         got: rd=%02h req=%0d addr=%04h wd=%02h vb=%0d dot=%0d line=%0d",
                             got.read_data, got.vram_request, got.vram_addr, got.vram_wdata,
                             got.vblank_flag, got.dot_now, got.line_now);
                end
            end
        endfunction

    endclass

endpackage

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the video scroll address unit
// Drives dot ticks and CPU register accesses through the input stream with
// random gaps, back-pressure and long stalls, and checks every result
// against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import vsa_pkg::*;
    import vsa_scoreboard_pkg::*;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // traffic shaping, written by the stimulus process only
    bit sender_quiet  = 1'b0;
    bit sink_quiet    = 1'b0;
    int hold_requests = 0;

    scroll_scoreboard sb = new();

    video_scroll_address_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: random back-pressure, long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < hold_requests)
            begin
                hold_left = 300;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (sink_quiet)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 16);
        end
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // one input transfer, with an occasional gap before it
    task automatic send_item(op_t op, reg_t ri, logic [7:0] d);
        if (!sender_quiet && $urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 2))
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b00000, d, ri};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.predict_item(op, ri, d);
    endtask

    task automatic send_dot();
        send_item(OP_DOT, reg_t'($urandom_range(0, 7)), 8'($urandom));
    endtask

    // stop offering until every predicted result has arrived
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    // one step of random traffic: ticks, bursts, register sequences, noise
    task automatic send_mixed();
        int   pick;
        op_t  op;
        reg_t ri;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_dot();
        else if (pick < 53)
            repeat ($urandom_range(8, 24)) send_dot();
        else if (pick < 59)
        begin
            // address pair, then data port traffic
            send_item(OP_WRITE, REG_ADDR, 8'($urandom));
            send_item(OP_WRITE, REG_ADDR, 8'($urandom));
            repeat ($urandom_range(1, 4))
                send_item($urandom_range(0, 1) ? OP_READ : OP_WRITE, REG_DATA, 8'($urandom));
        end
        else if (pick < 63)
        begin
            send_item(OP_WRITE, REG_SCROLL, 8'($urandom));
            send_item(OP_WRITE, REG_SCROLL, 8'($urandom));
        end
        else if (pick < 65)
            send_item(OP_NONE, reg_t'($urandom_range(0, 7)), 8'($urandom));
        else
        begin
            op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
            ri = reg_t'($urandom_range(0, 7));
            // never read a sprite entry that was not written
            if (op == OP_READ && ri == REG_OAM_DATA && !sb.oam_written[sb.oam_addr])
                op = OP_WRITE;
            send_item(op, ri, 8'($urandom));
        end
    endtask

    // stimulus and end of run
    initial
    begin : stimulus
        int iter;
        int wait_cycles;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset status, register extremes, sprite wrap, data port wrap
        send_item(OP_READ,  REG_STATUS,   8'h00);
        send_item(OP_WRITE, REG_CTRL,     8'hFF);
        send_item(OP_WRITE, REG_OAM_ADDR, 8'hFF);
        send_item(OP_WRITE, REG_OAM_DATA, 8'hA5);
        send_item(OP_WRITE, REG_OAM_DATA, 8'h00);
        send_item(OP_WRITE, REG_OAM_ADDR, 8'hFF);
        send_item(OP_READ,  REG_OAM_DATA, 8'h00);
        send_item(OP_READ,  REG_OAM_DATA, 8'hFF);
        send_item(OP_WRITE, REG_SCROLL,   8'hFF);
        send_item(OP_WRITE, REG_SCROLL,   8'hFF);
        send_item(OP_WRITE, REG_ADDR,     8'hFF);
        send_item(OP_WRITE, REG_ADDR,     8'hFF);
        send_item(OP_WRITE, REG_DATA,     8'hFF);
        send_item(OP_READ,  REG_DATA,     8'h00);
        send_item(OP_WRITE, REG_CTRL,     8'h00);
        send_item(OP_WRITE, REG_ADDR,     8'h3F);
        send_item(OP_WRITE, REG_ADDR,     8'hFF);
        send_item(OP_WRITE, REG_DATA,     8'h00);
        send_item(OP_READ,  REG_DATA,     8'hFF);
        send_item(OP_WRITE, REG_STATUS,   8'hFF);
        send_item(OP_READ,  REG_CTRL,     8'h00);
        send_item(OP_READ,  REG_SCROLL,   8'h00);
        send_item(OP_NONE,  REG_DATA,     8'hFF);
        send_item(OP_WRITE, REG_MASK,     8'h00);
        send_item(OP_WRITE, REG_MASK,     8'hFF);
        drain_results();

        // random traffic with a long stall and a pause
        for (iter = 0; iter < 760; iter++)
        begin
            case (iter)
                360:     hold_requests++;
                520:     drain_results();
                default: ;
            endcase
            sender_quiet = (iter >= 160 && iter < 260);
            sink_quiet   = (iter >= 200 && iter < 300);
            send_mixed();
        end

        // wait for the tail, then keep watching for stray results
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 10000 && sb.pending() > 0; wait_cycles++)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
